/* rtl/core/jet_pkg.sv */
// Shared types and constants for the Julia escape-time core.
package jet_pkg;

  // Screen size, each a power of two
  localparam int unsigned VIEW_WIDTH  = 1024;
  localparam int unsigned VIEW_HEIGHT = 1024;

  // Fixed-point formats: z and c are Q3.28
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned ZW        = 31;               // stored z component
  localparam int unsigned PW        = 61;               // registered product
  localparam int unsigned SW        = 62;               // Q6.56 sum
  localparam int unsigned NW        = SW - FRAC_BITS;   // floored new component

  // Pixel to coordinate step: 4 / size in Q3.28 is 2^(30 - log2(size))
  localparam int unsigned X_SHIFT = 30 - $clog2(VIEW_WIDTH);
  localparam int unsigned Y_SHIFT = 30 - $clog2(VIEW_HEIGHT);

  // Constants -2 (Q3.28), 2 (Q6.28) and 4 (Q5.56)
  localparam logic signed [ZW-1:0] MINUS_TWO_Q = -(ZW'(1) <<< 29);
  localparam logic signed [NW-1:0] TWO_Q       = NW'(1) <<< 29;
  localparam logic [PW-1:0]        FOUR_Q56    = PW'(1) << 58;

  // Point queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Register map (index = paddr[3:2])
  localparam int unsigned PAW = 4;
  localparam logic [1:0] REG_C_REAL   = 2'd0;
  localparam logic [1:0] REG_C_IMAG   = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;

  localparam logic [7:0] MAX_ITER_RESET = 8'd50;

  typedef struct packed {
    logic signed [ZW-1:0] c_real;
    logic signed [ZW-1:0] c_imag;
    logic [7:0]           max_iterations;
  } jet_cfg_t;

  typedef struct packed {
    logic signed [ZW-1:0] re;
    logic signed [ZW-1:0] im;
  } jet_point_t;

  // Queue write side
  typedef struct packed {
    logic       valid;
    jet_point_t point;
  } jet_push_t;

  // Queue read side
  typedef struct packed {
    logic       valid;
    jet_point_t point;
  } jet_head_t;

endpackage

/* rtl/core/jet_pix_if.sv */
// Pixel input channel: valid/ready with pixel coordinates.
interface jet_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

/* rtl/core/jet_cnt_if.sv */
// Result channel: valid/ready with the escape count.
interface jet_cnt_if;
  logic       valid;
  logic       ready;
  logic [7:0] escape_count;

  modport source (output valid, output escape_count, input ready);
  modport sink   (input valid, input escape_count, output ready);
endinterface

/* rtl/core/jet_front.sv */
// Front end: accepts pixels and maps them to starting points in Q3.28.
module jet_front
  import jet_pkg::*;
(
  jet_pix_if.sink    pix_i,
  input  logic       q_ready_i,
  output jet_push_t  push_o
);

  logic [ZW-1:0] x_idx;
  logic [ZW-1:0] y_idx;

  // Wrap the pixel into the view, then scale onto [-2, 2)
  always_comb begin
    x_idx = ZW'(pix_i.pixel_x) & ZW'(VIEW_WIDTH - 1);
    y_idx = ZW'(pix_i.pixel_y) & ZW'(VIEW_HEIGHT - 1);
    push_o.valid    = pix_i.valid;
    push_o.point.re = MINUS_TWO_Q + $signed(x_idx << X_SHIFT);
    push_o.point.im = MINUS_TWO_Q + $signed(y_idx << Y_SHIFT);
  end

  assign pix_i.ready = q_ready_i;

endmodule

/* rtl/core/jet_queue.sv */
// Short point queue decoupling the front end from the iteration engine.
module jet_queue
  import jet_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  jet_push_t push_i,
  output logic      ready_o,
  output jet_head_t head_o,
  input  logic      pop_i
);

  jet_point_t       mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o       = (count_q != QCW'(QDEPTH));
  assign head_o.valid  = (count_q != '0);
  assign head_o.point  = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && ready_o;
  assign do_pop  = pop_i && head_o.valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.point;
    end
  end

endmodule

/* rtl/core/jet_back.sv */
// Back end: iterates z = z*z + c and reports the escape count.
module jet_back
  import jet_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  jet_cfg_t   cfg_i,
  input  jet_head_t  head_i,
  output logic       pop_o,
  jet_cnt_if.source  cnt_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic signed [ZW-1:0] re_q, re_d, im_q, im_d;
  logic signed [PW-1:0] rr_q, ii_q, ri_q;
  logic [7:0]           iter_q, iter_d;
  logic                 out_vld_q, out_vld_d;
  logic [7:0]           out_cnt_q, out_cnt_d;

  logic signed [SW-1:0] cr, ci, re_sum, im_sum;
  logic signed [NW-1:0] nre, nim;
  logic [PW-1:0]        mag2;
  logic                 big, escaped, limit_hit, out_free;

  assign out_free = !out_vld_q || cnt_o.ready;

  // Update arithmetic from the registered products
  always_comb begin
    cr     = {{(SW - ZW - FRAC_BITS){cfg_i.c_real[ZW-1]}}, cfg_i.c_real, FRAC_BITS'(0)};
    ci     = {{(SW - ZW - FRAC_BITS){cfg_i.c_imag[ZW-1]}}, cfg_i.c_imag, FRAC_BITS'(0)};
    re_sum = SW'(rr_q) - SW'(ii_q) + cr;
    im_sum = (SW'(ri_q) <<< 1) + ci;
    // floor toward minus infinity
    nre    = re_sum[SW-1:FRAC_BITS];
    nim    = im_sum[SW-1:FRAC_BITS];
    // a component beyond 2 escapes for sure, so the square test is not needed
    big    = (nre > TWO_Q) || (nre < -TWO_Q) || (nim > TWO_Q) || (nim < -TWO_Q);
    // products here are the squares of the current z, both non-negative
    mag2      = $unsigned(rr_q) + $unsigned(ii_q);
    escaped   = (iter_q != '0) && (mag2 > FOUR_Q56);
    limit_hit = (iter_q == cfg_i.max_iterations);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    re_d      = re_q;
    im_d      = im_q;
    iter_d    = iter_q;
    out_vld_d = out_vld_q && !cnt_o.ready;
    out_cnt_d = out_cnt_q;
    pop_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          re_d    = head_i.point.re;
          im_d    = head_i.point.im;
          iter_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (escaped || limit_hit || big) begin
          // hold here until the result register frees up
          if (out_free) begin
            out_vld_d = 1'b1;
            out_cnt_d = escaped ? iter_q - 1'b1 : iter_q;
            state_d   = ST_IDLE;
          end
        end else begin
          re_d    = nre[ZW-1:0];
          im_d    = nim[ZW-1:0];
          iter_d  = iter_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    re_q      <= re_d;
    im_q      <= im_d;
    iter_q    <= iter_d;
    out_cnt_q <= out_cnt_d;
    if (state_q == ST_MUL) begin
      rr_q <= PW'(re_q * re_q);
      ii_q <= PW'(im_q * im_q);
      ri_q <= PW'(re_q * im_q);
    end
  end

  assign cnt_o.valid        = out_vld_q;
  assign cnt_o.escape_count = out_cnt_q;

endmodule

/* rtl/core/julia_escape_time_core.sv */
// Top level of the Julia escape-time core: config registers and the two halves.
//
// Usage: each pixel (pixel_x, pixel_y) transfer on pix_i yields exactly one
// escape_count transfer on cnt_o, in order. The pixel is wrapped into the view
// and mapped onto [-2, 2) in both axes as the starting z; the core repeats
// z = z*z + c in Q3.28 and counts iterations until |z|^2 exceeds 4, or up to
// max_iterations. c_real, c_imag and max_iterations sit on the APB port at
// byte addresses 0x0, 0x4 and 0x8; write them only while the core is idle.
// The front end maps a pixel in its transfer cycle and parks it in a
// two-entry queue, so up to two pixels are taken while one iterates. Each
// iteration passes through the engine's product state, then its add and
// escape-test state.
// Reset clears the queue, the engine and the output register and loads
// c = 0, max_iterations = 50. When the receiver stalls, the finished count
// waits in the output register; the engine holds its next finished result,
// and the queue keeps taking pixels until it is full.
module julia_escape_time_core
  import jet_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  jet_pix_if.sink           pix_i,
  jet_cnt_if.source         cnt_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAW-1:0]    paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  jet_cfg_t  cfg_q;
  jet_push_t push;
  jet_head_t head;
  logic      q_ready;
  logic      pop;
  logic      wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_real         <= '0;
      cfg_q.c_imag         <= '0;
      cfg_q.max_iterations <= MAX_ITER_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_C_REAL:   cfg_q.c_real         <= pwdata[ZW-1:0];
        REG_C_IMAG:   cfg_q.c_imag         <= pwdata[ZW-1:0];
        REG_MAX_ITER: cfg_q.max_iterations <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_C_REAL:   prdata = 32'(cfg_q.c_real);
      REG_C_IMAG:   prdata = 32'(cfg_q.c_imag);
      REG_MAX_ITER: prdata = {24'd0, cfg_q.max_iterations};
      default:      prdata = '0;
    endcase
  end

  jet_front u_front (
    .pix_i     (pix_i),
    .q_ready_i (q_ready),
    .push_o    (push)
  );

  jet_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  jet_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .pop_o  (pop),
    .cnt_o  (cnt_o)
  );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Julia escape-time core: APB setup, random pixels, count checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jet_pkg::*;

  // Address index that maps to no register
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Tracks the configuration, predicts escape counts, holds the outstanding ones
  class escape_tracker;
    longint      c_re;
    longint      c_im;
    int unsigned iter_limit;
    logic [7:0]  pending_counts[$];
    int          errors;

    function new();
      c_re       = 0;
      c_im       = 0;
      iter_limit = MAX_ITER_RESET;
      errors     = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_C_REAL:   c_re = $signed(data[ZW-1:0]);
        REG_C_IMAG:   c_im = $signed(data[ZW-1:0]);
        REG_MAX_ITER: iter_limit = data[7:0];
        default: ;  // unmapped address, write dropped
      endcase
    endfunction

    // Iterate z = z*z + c from the mapped pixel until |z|^2 > 4 or the limit
    function logic [7:0] iterate_pixel(logic [9:0] px, logic [9:0] py);
      longint            re, im, nre, nim;
      longint unsigned   ar, ai;
      longint unsigned   four_q56;
      int unsigned       n;
      four_q56 = 64'd1 << 58;
      re = -(longint'(1) <<< 29)
           + longint'(px % VIEW_WIDTH) * longint'((64'd1 << 30) / VIEW_WIDTH);
      im = -(longint'(1) <<< 29)
           + longint'(py % VIEW_HEIGHT) * longint'((64'd1 << 30) / VIEW_HEIGHT);
      n = 0;
      while (n < iter_limit) begin
        // exact Q8.56 sums, floored back to Q36.28
        nre = (re * re - im * im + (c_re <<< FRAC_BITS)) >>> FRAC_BITS;
        nim = (re * im * 2 + (c_im <<< FRAC_BITS)) >>> FRAC_BITS;
        ar  = (nre < 0) ? -nre : nre;
        ai  = (nim < 0) ? -nim : nim;
        re  = nre;
        im  = nim;
        if (ar * ar + ai * ai > four_q56) break;
        n++;
      end
      return n[7:0];
    endfunction

    function void note_pixel(logic [9:0] px, logic [9:0] py);
      pending_counts.push_back(iterate_pixel(px, py));
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_count(logic [7:0] got);
      logic [7:0] want;
      if (pending_counts.size() == 0) begin
        report($sformatf("escape_count %0d with no pixel outstanding", got));
      end else begin
        want = pending_counts.pop_front();
        if (got !== want)
          report($sformatf("escape_count %0d, predicted %0d", got, want));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PAW-1:0]    paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int send_idle_pct = 36;
  int recv_idle_pct = 67;

  escape_tracker tracker = new();

  jet_pix_if pix_if ();
  jet_cnt_if cnt_if ();

  julia_escape_time_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .cnt_o   (cnt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random back-pressure
  initial cnt_if.ready = 1'b0;
  always @(posedge clk_i) begin
    cnt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor: sampled mid-cycle, transfer completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && cnt_if.valid === 1'b1 && cnt_if.ready === 1'b1)
      tracker.check_count(cnt_if.escape_count);
  end

  // One pixel transfer, with random idle cycles ahead of it
  task automatic send_pixel(logic [9:0] px, logic [9:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.pixel_x <= px;
    pix_if.pixel_y <= py;
    @(negedge clk_i);
    while (pix_if.ready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_pixel(px, py);
  endtask

  // Hold the sender until every outstanding count has come back
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_counts.size() != 0);
  endtask

  // APB write: setup, access, then an idle phase
  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (pready !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    tracker.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Reconfigure c and the limit once the core is idle
  task automatic load_constants(logic [31:0] cre, logic [31:0] cim, logic [31:0] lim);
    wait_drained();
    apb_write(REG_C_REAL, cre);
    apb_write(REG_C_IMAG, cim);
    apb_write(REG_MAX_ITER, lim);
  endtask

  function automatic logic [31:0] random_c();
    return int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
  endfunction

  initial begin
    logic [31:0] cre, cim, lim;
    pix_if.valid   = 1'b0;
    pix_if.pixel_x = '0;
    pix_if.pixel_y = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: c = 0, limit 50; corners, center, mixed
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd256, 10'd768);

    // Classic connected Julia constant, full limit
    load_constants(-32'sd214748365, 32'sd41875931, 32'd255);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd600, 10'd480);
    send_pixel(10'd341, 10'd682);
    send_pixel(10'd1023, 10'd512);

    // Zero limit gives count zero
    load_constants(-32'sd214748365, 32'sd41875931, 32'd0);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);

    // Limit of one
    load_constants(32'd0, 32'd0, 32'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd512, 10'd512);

    // c far outside the +-2 box, both signs at full 31-bit reach
    load_constants(32'h3FFF_FFFF, 32'h4000_0000, 32'd8);
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd1023, 10'd0);
    load_constants(32'h4000_0000, 32'hFFFF_FFFF, 32'd8);
    send_pixel(10'd512, 10'd512);

    // c at the edges of the nominal range
    load_constants(-32'sd536870912, 32'sd536870912, 32'd255);
    send_pixel(10'd512, 10'd512);

    // Write to an unmapped address leaves the registers alone
    wait_drained();
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_pixel(10'd512, 10'd512);

    // Random phases, each with its own configuration
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 36;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cre = ($urandom_range(99) < 80) ? random_c() : $urandom();
      cim = ($urandom_range(99) < 80) ? random_c() : $urandom();
      if (ph == 3 || ph == 8)
        lim = 32'd255;
      else if ($urandom_range(99) < 8)
        lim = {24'($urandom_range(255)), 8'd0};  // low byte zero, upper bits random
      else
        lim = {24'($urandom_range(32'hFF_FFFF)), 8'(($urandom_range(64, 1)))};
      load_constants(cre, cim, lim);
      if ($urandom_range(3) == 0) apb_write(REG_UNUSED, $urandom());

      repeat (150) begin
        if ($urandom_range(63) == 0) wait_drained();
        if ($urandom_range(1))
          send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
        else
          send_pixel(10'($urandom_range(767, 256)), 10'($urandom_range(767, 256)));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_counts.size() == 0) begin
      $display("** julia_escape_time_core: PASSED **");
    end else begin
      $display("** julia_escape_time_core: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("** julia_escape_time_core: FAILED **");
    $finish;
  end

endmodule
